// ===== hw/rtl/cdet_pkg.sv =====
// ----------------------------------------------------------------------------
// cdet_pkg: shared types and constants of the countdown event table
// Table geometry, field widths, command and result codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cdet_pkg;

    localparam int SLOTS       = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 16;
    localparam int DELAY_W     = 16;
    localparam int INFO_W      = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_CANCEL = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        KIND_ADD_OK   = 3'd0,
        KIND_ADD_FULL = 3'd1,
        KIND_CANCEL   = 3'd2,
        KIND_FIRED    = 3'd3,
        KIND_IDLE     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_CANCEL,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic add;
        logic cancel;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/cdet_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdet_ctrl: command sequencer
// Accepts commands, steps the datapath through add, cancel and the tick scan.
// ----------------------------------------------------------------------------
module cdet_ctrl
    import cdet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    output logic       busy,
    output dp_cmd_t    dp_cmd,
    input  dp_stat_t   dp_stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        CMD_ADD:    state_next = ST_ADD;
                        CMD_TICK:   state_next = ST_SCAN;
                        CMD_CANCEL: state_next = ST_CANCEL;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:    state_next = ST_IDLE;
            ST_CANCEL: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (dp_stat.scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dp_cmd = '0;
        unique case (state_reg)
            ST_IDLE:   dp_cmd.load = start;
            ST_ADD:    dp_cmd.add = 1'b1;
            ST_CANCEL: dp_cmd.cancel = 1'b1;
            ST_SCAN:
            begin
                dp_cmd.step   = !dp_stat.scan_done;
                dp_cmd.finish = dp_stat.scan_done;
            end
            default:   dp_cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/cdet_dp.sv =====
// ----------------------------------------------------------------------------
// cdet_dp: event table datapath
// Entry register file, operand capture, tick scan with compaction, one
// pending fired result and the result output register.
// ----------------------------------------------------------------------------
module cdet_dp
    import cdet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            dp_cmd,
    output dp_stat_t           dp_stat,
    input  logic [DELAY_W-1:0] delay,
    input  logic [ID_W-1:0]    handler_id,
    input  logic [ID_W-1:0]    causer_id,
    input  logic [ID_W-1:0]    victim_id,
    input  logic [INFO_W-1:0]  info_word,
    input  logic [ID_W-1:0]    cancel_key,
    output logic               strobe,
    output logic [2:0]         kind,
    output logic [ID_W-1:0]    fired_handler,
    output logic [ID_W-1:0]    fired_causer,
    output logic [ID_W-1:0]    fired_victim,
    output logic [INFO_W-1:0]  fired_info,
    output logic               last
);

    // captured operands
    logic [DELAY_W-1:0] delay_reg;
    logic [ID_W-1:0]    handler_reg;
    logic [ID_W-1:0]    causer_reg;
    logic [ID_W-1:0]    victim_reg;
    logic [INFO_W-1:0]  info_reg;
    logic [ID_W-1:0]    key_reg;

    // entry register file
    logic [DELAY_W-1:0] cnt_mem [SLOTS];
    logic [ID_W-1:0]    hnd_mem [SLOTS];
    logic [ID_W-1:0]    cau_mem [SLOTS];
    logic [ID_W-1:0]    vic_mem [SLOTS];
    logic [INFO_W-1:0]  inf_mem [SLOTS];

    // scan control
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   rd_reg;
    logic [CNT_W-1:0]   wr_reg;
    logic [FIRE_W-1:0]  nfire_reg;
    logic               pend_valid_reg;
    logic [ID_W-1:0]    pend_h_reg;
    logic [ID_W-1:0]    pend_c_reg;
    logic [ID_W-1:0]    pend_v_reg;
    logic [INFO_W-1:0]  pend_i_reg;

    // result register
    logic               strobe_reg;
    kind_t              kind_reg;
    logic [ID_W-1:0]    out_h_reg;
    logic [ID_W-1:0]    out_c_reg;
    logic [ID_W-1:0]    out_v_reg;
    logic [INFO_W-1:0]  out_i_reg;
    logic               last_reg;

    logic               strobe_next;
    kind_t              kind_next;
    logic [ID_W-1:0]    out_h_next;
    logic [ID_W-1:0]    out_c_next;
    logic [ID_W-1:0]    out_v_next;
    logic [INFO_W-1:0]  out_i_next;
    logic               last_next;

    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic [DELAY_W-1:0] rd_cnt;
    logic               rd_zero;
    logic               rd_one;
    logic               fire_ok;
    logic               full;

    assign rd_idx  = rd_reg[IDX_W-1:0];
    assign wr_idx  = wr_reg[IDX_W-1:0];
    assign rd_cnt  = cnt_mem[rd_idx];
    assign rd_zero = (rd_cnt == '0);
    assign rd_one  = (rd_cnt == DELAY_W'(1));
    assign fire_ok = rd_one && (nfire_reg < FIRE_W'(MAX_RESULTS));
    assign full    = (used_reg == CNT_W'(SLOTS));

    assign dp_stat.scan_done = (rd_reg == used_reg);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            delay_reg   <= delay;
            handler_reg <= handler_id;
            causer_reg  <= causer_id;
            victim_reg  <= victim_id;
            info_reg    <= info_word;
            key_reg     <= cancel_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.add && !full)
        begin
            for (int k = SLOTS - 1; k > 0; k--)
            begin
                cnt_mem[k] <= cnt_mem[k-1];
                hnd_mem[k] <= hnd_mem[k-1];
                cau_mem[k] <= cau_mem[k-1];
                vic_mem[k] <= vic_mem[k-1];
                inf_mem[k] <= inf_mem[k-1];
            end
            cnt_mem[0] <= delay_reg;
            hnd_mem[0] <= handler_reg;
            cau_mem[0] <= causer_reg;
            vic_mem[0] <= victim_reg;
            inf_mem[0] <= info_reg;
        end
        else if (dp_cmd.cancel)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (hnd_mem[k] == key_reg || cau_mem[k] == key_reg
                    || vic_mem[k] == key_reg)
                begin
                    cnt_mem[k] <= '0;
                end
            end
        end
        else if (dp_cmd.step && !rd_zero && !rd_one)
        begin
            // compact survivors toward the head
            cnt_mem[wr_idx] <= rd_cnt - DELAY_W'(1);
            hnd_mem[wr_idx] <= hnd_mem[rd_idx];
            cau_mem[wr_idx] <= cau_mem[rd_idx];
            vic_mem[wr_idx] <= vic_mem[rd_idx];
            inf_mem[wr_idx] <= inf_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            nfire_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (dp_cmd.load)
        begin
            rd_reg         <= '0;
            wr_reg         <= '0;
            nfire_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (dp_cmd.add)
        begin
            if (!full)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
        end
        else if (dp_cmd.step)
        begin
            rd_reg <= rd_reg + CNT_W'(1);
            if (!rd_zero && !rd_one)
            begin
                wr_reg <= wr_reg + CNT_W'(1);
            end
            if (fire_ok)
            begin
                nfire_reg      <= nfire_reg + FIRE_W'(1);
                pend_valid_reg <= 1'b1;
            end
        end
        else if (dp_cmd.finish)
        begin
            used_reg       <= wr_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.step && fire_ok)
        begin
            pend_h_reg <= hnd_mem[rd_idx];
            pend_c_reg <= cau_mem[rd_idx];
            pend_v_reg <= vic_mem[rd_idx];
            pend_i_reg <= inf_mem[rd_idx];
        end
    end

    always_comb
    begin
        strobe_next = 1'b0;
        kind_next   = KIND_IDLE;
        out_h_next  = '0;
        out_c_next  = '0;
        out_v_next  = '0;
        out_i_next  = '0;
        last_next   = 1'b1;
        priority if (dp_cmd.add)
        begin
            strobe_next = 1'b1;
            kind_next   = full ? KIND_ADD_FULL : KIND_ADD_OK;
        end
        else if (dp_cmd.cancel)
        begin
            strobe_next = 1'b1;
            kind_next   = KIND_CANCEL;
        end
        else if ((dp_cmd.step && fire_ok && pend_valid_reg)
                 || (dp_cmd.finish && pend_valid_reg))
        begin
            // release the held fired entry; it is final only at scan end
            strobe_next = 1'b1;
            kind_next   = KIND_FIRED;
            out_h_next  = pend_h_reg;
            out_c_next  = pend_c_reg;
            out_v_next  = pend_v_reg;
            out_i_next  = pend_i_reg;
            last_next   = dp_cmd.finish;
        end
        else if (dp_cmd.finish)
        begin
            strobe_next = 1'b1;
            kind_next   = KIND_IDLE;
        end
        else
        begin
            strobe_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        out_h_reg <= out_h_next;
        out_c_reg <= out_c_next;
        out_v_reg <= out_v_next;
        out_i_reg <= out_i_next;
        last_reg  <= last_next;
    end

    assign strobe        = strobe_reg;
    assign kind          = kind_reg;
    assign fired_handler = out_h_reg;
    assign fired_causer  = out_c_reg;
    assign fired_victim  = out_v_reg;
    assign fired_info    = out_i_reg;
    assign last          = last_reg;

endmodule

// ===== hw/rtl/countdown_event_table_core.sv =====
// ----------------------------------------------------------------------------
// countdown_event_table_core: table of pending timed events
// Holds up to 16 events newest first; add, tick and cancel by key.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Add and cancel
// pass through their own controller state and show their single result
// in the cycle busy falls. A tick walks the table one entry a cycle
// through a single read index into the entry file; busy stays high for
// the walk over the entries in use. Fired events stream out during the
// walk, newest first, and the final result (marked by last) appears in the
// cycle busy falls. Command code 3 is taken and gives no result. Results
// are shown for one cycle under strobe and cannot be held off; a new
// command may transfer in the same cycle as the final result.
// ----------------------------------------------------------------------------
module countdown_event_table_core
    import cdet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [DELAY_W-1:0] delay,
    input  logic [ID_W-1:0]    handler_id,
    input  logic [ID_W-1:0]    causer_id,
    input  logic [ID_W-1:0]    victim_id,
    input  logic [INFO_W-1:0]  info_word,
    input  logic [ID_W-1:0]    cancel_key,
    output logic               strobe,
    output logic [2:0]         kind,
    output logic [ID_W-1:0]    fired_handler,
    output logic [ID_W-1:0]    fired_causer,
    output logic [ID_W-1:0]    fired_victim,
    output logic [INFO_W-1:0]  fired_info,
    output logic               last
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    cdet_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    cdet_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .delay         (delay),
        .handler_id    (handler_id),
        .causer_id     (causer_id),
        .victim_id     (victim_id),
        .info_word     (info_word),
        .cancel_key    (cancel_key),
        .strobe        (strobe),
        .kind          (kind),
        .fired_handler (fired_handler),
        .fired_causer  (fired_causer),
        .fired_victim  (fired_victim),
        .fired_info    (fired_info),
        .last          (last)
    );

endmodule

// ===== hw/rtl/cdet_checker.sv =====
// ----------------------------------------------------------------------------
// cdet_checker: port-level checks of the countdown event table
// Result framing and command-to-result timing as seen on the top level.
// ----------------------------------------------------------------------------
module cdet_checker
    import cdet_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         command,
    input logic               strobe,
    input logic [2:0]         kind,
    input logic [ID_W-1:0]    fired_handler,
    input logic [ID_W-1:0]    fired_causer,
    input logic [ID_W-1:0]    fired_victim,
    input logic [INFO_W-1:0]  fired_info,
    input logic               last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind != KIND_FIRED) |-> last)
    else $error("non-fired result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind != KIND_FIRED) |->
            (fired_handler == '0 && fired_causer == '0
             && fired_victim == '0 && fired_info == '0))
    else $error("tags not zero on non-fired result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_ADD || command == CMD_CANCEL))
            |-> ##2 (strobe && last && !busy))
    else $error("add or cancel result missing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
    else $error("intermediate result after tick ended");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_TICK) |=> busy)
    else $error("tick did not start a scan");

endmodule

bind countdown_event_table_core cdet_checker u_cdet_checker (.*);

// ===== verif/countdown_event_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// countdown_event_table_core_tb: self-checking bench for the event table
// Sends add, tick, cancel and reserved commands through the start/busy
// handshake and keeps its own copy of the table to predict every result.
// Each strobed result is checked field by field against the oldest
// prediction. A short directed sequence covers empty, full and mass-fire
// cases, then random traffic runs at three sender idle rates.
// ----------------------------------------------------------------------------
module countdown_event_table_core_tb;
    import cdet_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   handler;
        logic [ID_W-1:0]   causer;
        logic [ID_W-1:0]   victim;
        logic [INFO_W-1:0] info;
        logic              last;
    } table_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    handler_id;
    logic [ID_W-1:0]    causer_id;
    logic [ID_W-1:0]    victim_id;
    logic [INFO_W-1:0]  info_word;
    logic [ID_W-1:0]    cancel_key;
    logic               strobe;
    logic [2:0]         kind;
    logic [ID_W-1:0]    fired_handler;
    logic [ID_W-1:0]    fired_causer;
    logic [ID_W-1:0]    fired_victim;
    logic [INFO_W-1:0]  fired_info;
    logic               last;

    // predicted table contents, newest first
    logic               slot_valid[SLOTS];
    logic [DELAY_W-1:0] slot_count[SLOTS];
    logic [ID_W-1:0]    slot_handler[SLOTS];
    logic [ID_W-1:0]    slot_causer[SLOTS];
    logic [ID_W-1:0]    slot_victim[SLOTS];
    logic [INFO_W-1:0]  slot_info[SLOTS];

    table_result_t      expected_results[$];
    table_result_t      want;

    int errors = 0;
    int gap_pct = 0;
    int stall_cycles = 0;
    int n_adds = 0;
    int n_ticks = 0;
    int n_cancels = 0;
    int n_ignored = 0;
    int n_full = 0;
    int n_fired = 0;
    int n_quiet_ticks = 0;

    countdown_event_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .delay         (delay),
        .handler_id    (handler_id),
        .causer_id     (causer_id),
        .victim_id     (victim_id),
        .info_word     (info_word),
        .cancel_key    (cancel_key),
        .strobe        (strobe),
        .kind          (kind),
        .fired_handler (fired_handler),
        .fired_causer  (fired_causer),
        .fired_victim  (fired_victim),
        .fired_info    (fired_info),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic push_result(input kind_t k, input int slot, input logic is_last);
        table_result_t r;
        r = '0;
        r.kind = k;
        r.last = is_last;
        if (k == KIND_FIRED)
        begin
            r.handler = slot_handler[slot];
            r.causer  = slot_causer[slot];
            r.victim  = slot_victim[slot];
            r.info    = slot_info[slot];
        end
        expected_results.push_back(r);
    endtask

    task automatic move_slot(input int dst, input int src);
        slot_valid[dst]   = slot_valid[src];
        slot_count[dst]   = slot_count[src];
        slot_handler[dst] = slot_handler[src];
        slot_causer[dst]  = slot_causer[src];
        slot_victim[dst]  = slot_victim[src];
        slot_info[dst]    = slot_info[src];
    endtask

    // update the predicted table and queue the results of one command
    task automatic apply_command(input logic [1:0] cmd, input logic [DELAY_W-1:0] dly,
                                 input logic [ID_W-1:0] h, input logic [ID_W-1:0] c,
                                 input logic [ID_W-1:0] v, input logic [INFO_W-1:0] info,
                                 input logic [ID_W-1:0] key);
        int used;
        int i;
        int w;
        int fired;
        used = 0;
        while (used < SLOTS && slot_valid[used])
            used++;
        case (cmd)
            CMD_ADD:
            begin
                n_adds++;
                if (used >= SLOTS)
                    push_result(KIND_ADD_FULL, 0, 1'b1);
                else
                begin
                    for (i = used; i > 0; i--)
                        move_slot(i, i - 1);
                    slot_valid[0]   = 1'b1;
                    slot_count[0]   = dly;
                    slot_handler[0] = h;
                    slot_causer[0]  = c;
                    slot_victim[0]  = v;
                    slot_info[0]    = info;
                    push_result(KIND_ADD_OK, 0, 1'b1);
                end
            end
            CMD_TICK:
            begin
                n_ticks++;
                w = 0;
                fired = 0;
                for (i = 0; i < used; i++)
                begin
                    if (slot_count[i] == '0)
                        continue;
                    if (slot_count[i] == 1)
                    begin
                        if (fired < MAX_RESULTS)
                        begin
                            push_result(KIND_FIRED, i, 1'b0);
                            fired++;
                        end
                        continue;
                    end
                    slot_count[i] = slot_count[i] - 1'b1;
                    if (w != i)
                        move_slot(w, i);
                    w++;
                end
                for (i = w; i < SLOTS; i++)
                    slot_valid[i] = 1'b0;
                if (fired == 0)
                    push_result(KIND_IDLE, 0, 1'b1);
                else
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
            CMD_CANCEL:
            begin
                n_cancels++;
                for (i = 0; i < used; i++)
                    if (slot_causer[i] == key || slot_victim[i] == key
                        || slot_handler[i] == key)
                        slot_count[i] = '0;
                push_result(KIND_CANCEL, 0, 1'b1);
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [DELAY_W-1:0] dly,
                            input logic [ID_W-1:0] h, input logic [ID_W-1:0] c,
                            input logic [ID_W-1:0] v, input logic [INFO_W-1:0] info,
                            input logic [ID_W-1:0] key);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        delay      <= dly;
        handler_id <= h;
        causer_id  <= c;
        victim_id  <= v;
        info_word  <= info;
        cancel_key <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_command(cmd, dly, h, c, v, info, key);
    endtask

    task automatic add_event(input logic [DELAY_W-1:0] dly, input logic [ID_W-1:0] h,
                             input logic [ID_W-1:0] c, input logic [ID_W-1:0] v,
                             input logic [INFO_W-1:0] info);
        send_cmd(CMD_ADD, dly, h, c, v, info, ID_W'($urandom));
    endtask

    task automatic send_tick();
        send_cmd(CMD_TICK, DELAY_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                 ID_W'($urandom), $urandom, ID_W'($urandom));
    endtask

    task automatic cancel_by(input logic [ID_W-1:0] key);
        send_cmd(CMD_CANCEL, DELAY_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                 ID_W'($urandom), $urandom, key);
    endtask

    task automatic send_reserved();
        send_cmd(CMD_RESERVED, DELAY_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                 ID_W'($urandom), $urandom, ID_W'($urandom));
    endtask

    // hold start low until every predicted result has been seen
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 70)
            return ID_W'($urandom_range(1, 8));
        return ID_W'($urandom);
    endfunction

    task automatic test_single_events();
        send_tick();
        add_event('1, '1, '1, '1, '1);
        add_event('0, 16'h0001, 16'h0002, 16'h0003, 32'h0000_0004);
        add_event(16'd1, '0, '0, '0, '0);
        cancel_by(16'h5A5A);
        cancel_by('1);
        cancel_by('1);
        send_reserved();
        send_tick();
        wait_drained();
    endtask

    task automatic test_full_table();
        int i;
        for (i = 0; i < SLOTS; i++)
            add_event(16'd1, ID_W'(16'h0100 + i), ID_W'(16'h0200 + i),
                      ID_W'(16'h0300 + i), {16'hC0DE, 16'(i)});
        add_event(16'd1, '1, '1, '1, '1);
        send_tick();
        send_tick();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        int sent;
        int roll;
        logic [DELAY_W-1:0] dly;
        gap_pct = idle_pct;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    dly = '0;
                else if (roll < 90)
                    dly = DELAY_W'($urandom_range(1, 6));
                else
                    dly = DELAY_W'($urandom);
                add_event(dly, pick_id(), pick_id(), pick_id(), $urandom);
                sent++;
            end
            else if (roll < 75)
            begin
                send_tick();
                sent++;
            end
            else if (roll < 93)
            begin
                cancel_by(pick_id());
                sent++;
            end
            else
                send_reserved();
        end
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [INFO_W-1:0] exp_val,
                               input logic [INFO_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: expected none, actual kind %0d",
                         $time, kind);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", INFO_W'(want.kind), INFO_W'(kind));
                check_field("fired_handler", INFO_W'(want.handler), INFO_W'(fired_handler));
                check_field("fired_causer", INFO_W'(want.causer), INFO_W'(fired_causer));
                check_field("fired_victim", INFO_W'(want.victim), INFO_W'(fired_victim));
                check_field("fired_info", want.info, fired_info);
                check_field("last", INFO_W'(want.last), INFO_W'(last));
                case (want.kind)
                    KIND_FIRED:    n_fired++;
                    KIND_ADD_FULL: n_full++;
                    KIND_IDLE:     n_quiet_ticks++;
                    default:       ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            slot_valid[i] = 1'b0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        command    <= '0;
        delay      <= '0;
        handler_id <= '0;
        causer_id  <= '0;
        victim_id  <= '0;
        info_word  <= '0;
        cancel_key <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_events();
        test_full_table();
        test_random_traffic(130, 25);
        test_random_traffic(130, 55);
        test_random_traffic(140, 0);

        start <= 1'b0;
        repeat (SLOTS + 4) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived: expected %0d, actual 0",
                     $time, expected_results.size(), expected_results.size());
        end

        $display("Ran %0d adds, %0d ticks, %0d cancels and %0d ignored commands.",
                 n_adds, n_ticks, n_cancels, n_ignored);
        $display("Saw %0d fired events, %0d table-full refusals, %0d quiet ticks.",
                 n_fired, n_full, n_quiet_ticks);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cdet_pkg.sv
hw/rtl/cdet_ctrl.sv
hw/rtl/cdet_dp.sv
hw/rtl/countdown_event_table_core.sv
hw/rtl/cdet_checker.sv
verif/countdown_event_table_core_tb.sv
